### rtl/core/mkpsc_pkg.sv
// Shared types and constants of the mixed-kernel polar SC decoder core.
package mkpsc_pkg;

  localparam int POS_W     = 13;
  localparam int CH_W      = 16;
  localparam int OUT_W     = 16;
  localparam int CMD_W     = 2;
  localparam int LEN_W     = 20;
  localparam int DG_SLOTS  = 12;
  localparam int NS_W      = 4;
  localparam int KT_W      = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CALC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam logic [1:0] KER_23  = 2'd0;
  localparam logic [1:0] KER_753 = 2'd1;
  localparam logic [1:0] KER_427 = 2'd2;
  localparam logic [1:0] KER_657 = 2'd3;

  localparam logic CFG_NUM_STAGES   = 1'b0;
  localparam logic CFG_KERNEL_TYPES = 1'b1;

  typedef struct packed {
    logic [NS_W-1:0]                  act_n;
    logic [DG_SLOTS-1:0][1:0]         kind;
    logic [DG_SLOTS-1:0][LEN_W-1:0]   w;
    logic [LEN_W-1:0]                 len;
    logic                             len_ok;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         pos;
    logic signed [CH_W-1:0]   llr;
    logic                     dec;
    logic [DG_SLOTS-1:0][1:0] dg;
  } item_t;

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_DIG  = 3'b010,
    FS_PUSH = 3'b100
  } front_state_t;

  typedef enum logic [12:0] {
    B_IDLE  = 13'b0000000000001,
    B_LOAD  = 13'b0000000000010,
    B_SETD  = 13'b0000000000100,
    B_CDESC = 13'b0000000001000,
    B_RD    = 13'b0000000010000,
    B_CAP   = 13'b0000000100000,
    B_CALC  = 13'b0000001000000,
    B_RET   = 13'b0000010000000,
    B_NEXT  = 13'b0000100000000,
    B_HDESC = 13'b0001000000000,
    B_HWR   = 13'b0010000000000,
    B_ORD   = 13'b0100000000000,
    B_OWAIT = 13'b1000000000000
  } back_state_t;

endpackage

### rtl/core/mkpsc_cfg.sv
// Configuration registers and derived stage weights and code length.
module mkpsc_cfg #(
  parameter int MAX_STAGES = 8,
  parameter int MAX_LENGTH = 8192
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [mkpsc_pkg::KT_W-1:0] cfg_data,
  output mkpsc_pkg::cfg_t            cfg,
  output logic                       hold
);

  logic [mkpsc_pkg::NS_W-1:0]   num_stages;
  logic [mkpsc_pkg::KT_W-1:0]   kernel_types;
  logic [mkpsc_pkg::NS_W-1:0]   n;
  logic [2*mkpsc_pkg::DG_SLOTS-1:0] ktx;
  logic [mkpsc_pkg::LEN_W-1:0]  len;
  mkpsc_pkg::cfg_t              cfg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_stages   <= mkpsc_pkg::NS_W'(1);
      kernel_types <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mkpsc_pkg::CFG_NUM_STAGES:   num_stages   <= cfg_data[mkpsc_pkg::NS_W-1:0];
        mkpsc_pkg::CFG_KERNEL_TYPES: kernel_types <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    n = num_stages;
    if (n == '0) n = mkpsc_pkg::NS_W'(1);
    if (n > mkpsc_pkg::NS_W'(MAX_STAGES)) n = mkpsc_pkg::NS_W'(MAX_STAGES);
    ktx = (2*mkpsc_pkg::DG_SLOTS)'(kernel_types);
    len = mkpsc_pkg::LEN_W'(1);
    cfg_next = '0;
    cfg_next.act_n = n;
    for (int s = 0; s < mkpsc_pkg::DG_SLOTS; s++) begin
      cfg_next.kind[s] = ktx[2*s +: 2];
      if (mkpsc_pkg::NS_W'(s) < n) begin
        cfg_next.w[s] = len;
        len = (ktx[2*s +: 2] == mkpsc_pkg::KER_23) ? (len << 1) : (len + (len << 1));
      end
    end
    cfg_next.len    = len;
    cfg_next.len_ok = (len <= mkpsc_pkg::LEN_W'(MAX_LENGTH));
  end

  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

  always_ff @(posedge clk) begin
    hold <= rst | cfg_we;
  end

endmodule

### rtl/core/mkpsc_front.sv
// Front end: takes commands, drops invalid ones, splits positions into digits.
module mkpsc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,
  input  mkpsc_pkg::cfg_t       cfg,
  input  logic                  hold,
  input  logic                  q_full,
  output logic                  q_push,
  output mkpsc_pkg::item_t      q_item
);

  mkpsc_pkg::front_state_t    state;
  mkpsc_pkg::item_t           item;
  logic [mkpsc_pkg::POS_W-1:0] p;
  logic [mkpsc_pkg::NS_W-1:0]  s;
  logic [28:0]                 prod;
  logic [mkpsc_pkg::POS_W-1:0] q3;
  logic [mkpsc_pkg::POS_W-1:0] rem;
  logic [mkpsc_pkg::POS_W-1:0] p_next;
  logic [1:0]                  digit;
  logic [mkpsc_pkg::CMD_W-1:0] in_cmd;
  logic [mkpsc_pkg::POS_W-1:0] in_pos;

  assign in_cmd   = s_tdata[1:0];
  assign in_pos   = s_tdata[14:2];
  assign s_tready = (state == mkpsc_pkg::FS_IDLE) && !hold;
  assign q_push   = (state == mkpsc_pkg::FS_PUSH) && !q_full;
  assign q_item   = item;

  always_comb begin
    prod = 29'(p) * 29'(21846);
    q3   = prod[28:16];
    rem  = p - (q3 + (q3 << 1));
    if (cfg.kind[s] == mkpsc_pkg::KER_23) begin
      digit  = {1'b0, p[0]};
      p_next = p >> 1;
    end else begin
      digit  = rem[1:0];
      p_next = q3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mkpsc_pkg::FS_IDLE;
    end else begin
      unique case (state)
        mkpsc_pkg::FS_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (in_cmd != mkpsc_pkg::CMD_NONE && cfg.len_ok &&
                mkpsc_pkg::LEN_W'(in_pos) < cfg.len) begin
              state <= mkpsc_pkg::FS_DIG;
            end
          end
        end
        mkpsc_pkg::FS_DIG: begin
          if (s + mkpsc_pkg::NS_W'(1) == cfg.act_n) state <= mkpsc_pkg::FS_PUSH;
        end
        mkpsc_pkg::FS_PUSH: begin
          if (!q_full) state <= mkpsc_pkg::FS_IDLE;
        end
        default: state <= mkpsc_pkg::FS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == mkpsc_pkg::FS_IDLE) begin
      item.cmd <= in_cmd;
      item.pos <= in_pos;
      item.llr <= s_tdata[30:15];
      item.dec <= s_tdata[31];
      item.dg  <= '0;
      p        <= in_pos;
      s        <= '0;
    end else if (state == mkpsc_pkg::FS_DIG) begin
      item.dg[s] <= digit;
      p          <= p_next;
      s          <= s + mkpsc_pkg::NS_W'(1);
    end
  end

endmodule

### rtl/core/mkpsc_queue.sv
// Two-entry command queue between front and back end.
module mkpsc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mkpsc_pkg::item_t push_item,
  input  logic             pop,
  output mkpsc_pkg::item_t head,
  output logic             empty,
  output logic             full
);

  mkpsc_pkg::item_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

### rtl/core/mkpsc_back.sv
// Back end: kernel tree walk over the LLR and decision memories.
module mkpsc_back #(
  parameter int MAX_STAGES = 8,
  parameter int MAX_LENGTH = 8192,
  parameter int LLR_WIDTH  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  mkpsc_pkg::cfg_t  cfg,
  input  mkpsc_pkg::item_t head,
  input  logic             empty,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata
);

  localparam int DEPTH  = (MAX_STAGES + 1) * MAX_LENGTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SITE_W = $clog2(MAX_LENGTH);
  localparam int WW     = ((LLR_WIDTH > mkpsc_pkg::CH_W) ? LLR_WIDTH : mkpsc_pkg::CH_W) + 3;
  localparam logic signed [WW-1:0] L_MAX = WW'((64'sd1 <<< (LLR_WIDTH - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] L_MIN = WW'(-(64'sd1 <<< (LLR_WIDTH - 1)));
  localparam logic signed [WW-1:0] O_MAX = WW'(32767);
  localparam logic signed [WW-1:0] O_MIN = WW'(-32768);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [mkpsc_pkg::NS_W-1:0] lvl,
                                                 input logic [SITE_W-1:0] st);
    return ADDR_W'(lvl) * ADDR_W'(MAX_LENGTH) + ADDR_W'(st);
  endfunction

  function automatic logic signed [WW-1:0] min_sum(input logic signed [WW-1:0] a,
                                                   input logic signed [WW-1:0] b);
    logic signed [WW-1:0] ma;
    logic signed [WW-1:0] mb;
    logic signed [WW-1:0] m;
    ma = a[WW-1] ? -a : a;
    mb = b[WW-1] ? -b : b;
    m  = (ma < mb) ? ma : mb;
    return (a[WW-1] != b[WW-1]) ? -m : m;
  endfunction

  function automatic logic signed [WW-1:0] flip(input logic h, input logic signed [WW-1:0] v);
    return h ? -v : v;
  endfunction

  function automatic logic signed [LLR_WIDTH-1:0] sat_llr(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] t;
    t = (v > L_MAX) ? L_MAX : ((v < L_MIN) ? L_MIN : v);
    return t[LLR_WIDTH-1:0];
  endfunction

  logic signed [LLR_WIDTH-1:0] llr_mem [DEPTH];
  logic                        dec_mem [DEPTH];

  mkpsc_pkg::back_state_t       state;
  logic                         mode_hd;
  logic [mkpsc_pkg::POS_W-1:0]  pos;
  logic signed [mkpsc_pkg::CH_W-1:0] llr_in;
  logic                         dec_in;
  logic [mkpsc_pkg::DG_SLOTS-1:0][1:0] dg;
  logic [mkpsc_pkg::NS_W-1:0]   lv;
  logic [SITE_W-1:0]            site;
  logic [SITE_W-1:0]            nbase;
  logic [SITE_W-1:0]            rsite;
  logic [1:0]                   nd;
  logic [1:0]                   rk;
  logic [1:0]                   wk;
  logic signed [LLR_WIDTH-1:0]  x [3];
  logic                         h [3];

  logic                         llr_we;
  logic [ADDR_W-1:0]            llr_waddr;
  logic signed [LLR_WIDTH-1:0]  llr_wdata;
  logic [ADDR_W-1:0]            llr_raddr;
  logic signed [LLR_WIDTH-1:0]  llr_rdata;
  logic                         dec_we;
  logic [ADDR_W-1:0]            dec_waddr;
  logic                         dec_wdata;
  logic [ADDR_W-1:0]            dec_raddr;
  logic                         dec_rdata;

  logic [1:0]                   kd_l;
  logic [1:0]                   rm1;
  logic [SITE_W-1:0]            wl;
  logic [1:0]                   dl;
  logic [SITE_W-1:0]            dw;
  logic [SITE_W-1:0]            rw;
  logic [mkpsc_pkg::NS_W-1:0]   lv1;
  logic signed [WW-1:0]         x0, x1, x2, sub, v, ov;
  logic [2:0]                   c;

  always_comb begin
    kd_l = cfg.kind[lv];
    rm1  = (kd_l == mkpsc_pkg::KER_23) ? 2'd1 : 2'd2;
    wl   = SITE_W'(cfg.w[lv]);
    dl   = dg[lv];
    dw   = dl[1] ? (wl << 1) : (dl[0] ? wl : '0);
    rw   = rm1[1] ? (wl << 1) : wl;
    lv1  = lv + mkpsc_pkg::NS_W'(1);
  end

  always_comb begin
    x0  = WW'(x[0]);
    x1  = WW'(x[1]);
    x2  = WW'(x[2]);
    sub = '0;
    case (kd_l)
      mkpsc_pkg::KER_23:
        v = (nd == 2'd0) ? min_sum(x0, x1) : x1 + flip(h[0], x0);
      mkpsc_pkg::KER_753: begin
        if (nd == 2'd0) v = min_sum(x0, min_sum(x1, x2));
        else if (nd == 2'd1) v = min_sum(x1, x2) + flip(h[0], x0);
        else v = flip(h[0], x1) + flip(h[0] ^ h[1], x2);
      end
      mkpsc_pkg::KER_427: begin
        sub = x2 + flip(h[0], x0);
        if (nd == 2'd0) v = min_sum(x0, x2);
        else if (nd == 2'd1) v = min_sum(x1, sub);
        else v = flip(h[0], x0) + flip(h[1], x1) + x2;
      end
      default: begin
        sub = flip(h[0], x2) + x0;
        if (nd == 2'd0) v = min_sum(x0, x2);
        else if (nd == 2'd1) v = min_sum(x1, sub);
        else v = flip(h[0] ^ h[1], x0) + flip(h[0], x1) + flip(h[1], x2);
      end
    endcase
    case (kd_l)
      mkpsc_pkg::KER_23:  c = {1'b0, h[1], h[0] ^ h[1]};
      mkpsc_pkg::KER_753: c = {h[0] ^ h[1] ^ h[2], h[0] ^ h[2], h[0] ^ h[1]};
      mkpsc_pkg::KER_427: c = {h[2], h[1] ^ h[2], h[0] ^ h[2]};
      default:            c = {h[1] ^ h[2], h[0] ^ h[2], h[0] ^ h[1] ^ h[2]};
    endcase
    ov = WW'(llr_rdata);
  end

  always_comb begin
    llr_we    = (state == mkpsc_pkg::B_LOAD) || (state == mkpsc_pkg::B_CALC);
    llr_waddr = (state == mkpsc_pkg::B_LOAD) ? addr_of(cfg.act_n, site) : addr_of(lv, site);
    llr_wdata = (state == mkpsc_pkg::B_LOAD) ? sat_llr(WW'(llr_in)) : sat_llr(v);
    llr_raddr = (state == mkpsc_pkg::B_ORD || state == mkpsc_pkg::B_OWAIT) ?
                addr_of('0, site) : addr_of(lv1, rsite);
    dec_we    = (state == mkpsc_pkg::B_SETD) || (state == mkpsc_pkg::B_HWR);
    dec_waddr = (state == mkpsc_pkg::B_SETD) ? addr_of('0, site) : addr_of(lv1, rsite);
    dec_wdata = (state == mkpsc_pkg::B_SETD) ? dec_in : c[wk];
    dec_raddr = addr_of(lv, rsite);
  end

  always_ff @(posedge clk) begin
    if (llr_we) llr_mem[llr_waddr] <= llr_wdata;
    llr_rdata <= llr_mem[llr_raddr];
  end

  always_ff @(posedge clk) begin
    if (dec_we) dec_mem[dec_waddr] <= dec_wdata;
    dec_rdata <= dec_mem[dec_raddr];
  end

  assign pop = (state == mkpsc_pkg::B_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mkpsc_pkg::B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        mkpsc_pkg::B_IDLE: begin
          if (!empty) begin
            unique case (head.cmd)
              mkpsc_pkg::CMD_LOAD: state <= mkpsc_pkg::B_LOAD;
              mkpsc_pkg::CMD_CALC: state <= mkpsc_pkg::B_CDESC;
              default:             state <= mkpsc_pkg::B_SETD;
            endcase
          end
        end
        mkpsc_pkg::B_LOAD: state <= mkpsc_pkg::B_IDLE;
        mkpsc_pkg::B_SETD: state <= mkpsc_pkg::B_HDESC;
        mkpsc_pkg::B_CDESC: begin
          if (lv >= cfg.act_n) state <= mkpsc_pkg::B_RET;
          else if (dl != 2'd0) state <= mkpsc_pkg::B_RD;
        end
        mkpsc_pkg::B_RD: state <= mkpsc_pkg::B_CAP;
        mkpsc_pkg::B_CAP: begin
          if (rk == rm1) state <= mode_hd ? mkpsc_pkg::B_HWR : mkpsc_pkg::B_CALC;
          else state <= mkpsc_pkg::B_RD;
        end
        mkpsc_pkg::B_CALC: state <= mkpsc_pkg::B_RET;
        mkpsc_pkg::B_RET: begin
          if (lv == '0) state <= mode_hd ? mkpsc_pkg::B_IDLE : mkpsc_pkg::B_ORD;
          else state <= mkpsc_pkg::B_NEXT;
        end
        mkpsc_pkg::B_NEXT: begin
          if (dl < rm1) state <= mode_hd ? mkpsc_pkg::B_HDESC : mkpsc_pkg::B_CDESC;
          else state <= mode_hd ? mkpsc_pkg::B_RET : mkpsc_pkg::B_RD;
        end
        mkpsc_pkg::B_HDESC: begin
          if (lv >= cfg.act_n || dl != rm1) state <= mkpsc_pkg::B_RET;
          else state <= mkpsc_pkg::B_RD;
        end
        mkpsc_pkg::B_HWR: begin
          if (wk == rm1) state <= mkpsc_pkg::B_HDESC;
        end
        mkpsc_pkg::B_ORD: state <= mkpsc_pkg::B_OWAIT;
        mkpsc_pkg::B_OWAIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= mkpsc_pkg::B_IDLE;
          end
        end
        default: state <= mkpsc_pkg::B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      mkpsc_pkg::B_IDLE: begin
        mode_hd <= (head.cmd == mkpsc_pkg::CMD_SET);
        pos     <= head.pos;
        llr_in  <= head.llr;
        dec_in  <= head.dec;
        dg      <= head.dg;
        site    <= SITE_W'(head.pos);
        lv      <= '0;
      end
      mkpsc_pkg::B_CDESC: begin
        if (lv < cfg.act_n) begin
          if (dl != 2'd0) begin
            nd    <= dl;
            nbase <= site - dw;
            rsite <= site - dw;
            rk    <= 2'd0;
          end else begin
            lv <= lv1;
          end
        end
      end
      mkpsc_pkg::B_RD: ;
      mkpsc_pkg::B_CAP: begin
        x[rk] <= llr_rdata;
        h[rk] <= dec_rdata;
        if (rk == rm1) begin
          rsite <= nbase;
          wk    <= 2'd0;
        end else begin
          rk    <= rk + 2'd1;
          rsite <= rsite + wl;
        end
      end
      mkpsc_pkg::B_RET: begin
        if (lv != '0) lv <= lv - mkpsc_pkg::NS_W'(1);
      end
      mkpsc_pkg::B_NEXT: begin
        if (dl < rm1) begin
          dg[lv] <= dl + 2'd1;
          site   <= site + wl;
          lv     <= lv1;
        end else if (!mode_hd) begin
          dg[lv] <= 2'd0;
          site   <= site - rw;
          nd     <= 2'd0;
          nbase  <= site - rw;
          rsite  <= site - rw;
          rk     <= 2'd0;
        end
      end
      mkpsc_pkg::B_HDESC: begin
        if (lv < cfg.act_n && dl == rm1) begin
          nbase <= site - rw;
          rsite <= site - rw;
          rk    <= 2'd0;
        end
      end
      mkpsc_pkg::B_HWR: begin
        if (wk == rm1) begin
          dg[lv] <= 2'd0;
          site   <= nbase;
          lv     <= lv1;
        end else begin
          wk    <= wk + 2'd1;
          rsite <= rsite + wl;
        end
      end
      mkpsc_pkg::B_OWAIT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {3'b000,
                      ((ov > O_MAX) ? O_MAX[mkpsc_pkg::OUT_W-1:0] :
                       (ov < O_MIN) ? O_MIN[mkpsc_pkg::OUT_W-1:0] : ov[mkpsc_pkg::OUT_W-1:0]),
                      pos};
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/mixed_kernel_polar_sc_decoder_core.sv
// Top level of the mixed-kernel polar successive-cancellation decoder core.
//   channel | dir | transaction | contents
//   s_      | in  | command     | tdata: command[1:0] position[14:2] channel_llr[30:15] decision[31]
//   m_      | out | bit LLR     | tdata: bit_position[12:0] bit_llr[28:13], zero pad
//   cfg_    | in  | reg write   | cfg_we, cfg_index (0 num_stages, 1 kernel_types), cfg_data
// Front end splits a position into digits, one per active stage.
// Load is a single LLR write in the back end; decision/compute walk the kernel tree
// node by node through LLR/decision memories with separate read and write ports.
// Reset is synchronous; input is held off in the cycle after reset or a register write.
// A two-entry queue and the output register let each side stall on its own.
module mixed_kernel_polar_sc_decoder_core #(
  parameter int MAX_STAGES = 8,
  parameter int MAX_LENGTH = 8192,
  parameter int LLR_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // command, position, channel_llr, decision
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // bit_position, bit_llr, zero pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  mkpsc_pkg::cfg_t  cfg;
  mkpsc_pkg::item_t q_in;
  mkpsc_pkg::item_t q_head;
  logic             hold;
  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  logic             q_full;

  mkpsc_cfg #(.MAX_STAGES(MAX_STAGES), .MAX_LENGTH(MAX_LENGTH)) u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg, .hold
  );

  mkpsc_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .cfg, .hold,
    .q_full, .q_push, .q_item(q_in)
  );

  mkpsc_queue u_queue (
    .clk, .rst, .push(q_push), .push_item(q_in), .pop(q_pop),
    .head(q_head), .empty(q_empty), .full(q_full)
  );

  mkpsc_back #(.MAX_STAGES(MAX_STAGES), .MAX_LENGTH(MAX_LENGTH), .LLR_WIDTH(LLR_WIDTH)) u_back (
    .clk, .rst, .cfg, .head(q_head), .empty(q_empty), .pop(q_pop),
    .m_tvalid, .m_tready, .m_tdata
  );

endmodule

### rtl/core/mkpsc_checker.sv
// Port-level checker for the decoder core and its bind.
module mkpsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        cfg_we
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("activity right after reset");

  a_cfg_block: assert property (@(posedge clk) cfg_we |=> !s_tready)
    else $error("input taken right after register write");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:29] == 3'b000)
    else $error("output pad bits set");

endmodule

bind mixed_kernel_polar_sc_decoder_core mkpsc_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .cfg_we(cfg_we)
);

### verif/tb.sv
// Testbench for mixed_kernel_polar_sc_decoder_core: full SC decode frames checked against a predictor.
`timescale 1ns / 100ps
module tb;
  import mkpsc_pkg::*;

  localparam int LVL_SZ   = 8192;
  localparam int DRAIN    = 20000;
  localparam int WD_LIMIT = 100000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  mixed_kernel_polar_sc_decoder_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic [POS_W-1:0]        pos;
    logic signed [OUT_W-1:0] llr;
  } bit_llr_t;

  bit_llr_t bit_llr_q[$];
  int       errors = 0;
  int       src_idle_pct = 0;
  int       snk_stall_pct = 0;
  bit       snk_hold = 1'b0;
  int       rand_items = 0;

  // decoder image
  logic [NS_W-1:0] ns_reg = 1;
  logic [KT_W-1:0] kt_reg = 0;
  int              act_n, act_len;
  int              wgt[8];
  int              dg[8];
  longint          llr_mem[0:9*LVL_SZ-1];
  bit              hd_mem[0:9*LVL_SZ-1];

  function automatic int kind_at(int s);
    return (s >= 8) ? 0 : int'(kt_reg[2*s +: 2]);
  endfunction

  function automatic int radix_at(int s);
    return (kind_at(s) == KER_23) ? 2 : 3;
  endfunction

  function automatic void geometry();
    int n, l;
    n = (ns_reg < 1) ? 1 : (ns_reg > 8) ? 8 : int'(ns_reg);
    act_n = n;
    l = 1;
    for (int s = 0; s < n; s++) begin
      wgt[s] = l;
      l *= radix_at(s);
    end
    act_len = l;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int site_now();
    int a = 0;
    for (int i = 0; i < act_n; i++) a += dg[i] * wgt[i];
    return a;
  endfunction

  function automatic longint msum(longint a, longint b);
    longint ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma < mb) ? ma : mb;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint fl(bit f, longint v);
    return f ? -v : v;
  endfunction

  function automatic void node_llr(int lv);
    int r, t, d;
    int st[3];
    longint x[3];
    bit h[3];
    longint v;
    if (lv >= act_n) return;
    r = radix_at(lv);
    t = kind_at(lv);
    d = dg[lv];
    for (int k = 0; k < r; k++) begin
      dg[lv] = k;
      st[k] = site_now();
      if (d == 0) node_llr(lv + 1);
    end
    dg[lv] = d;
    for (int k = 0; k < r; k++) begin
      x[k] = llr_mem[(lv + 1) * LVL_SZ + st[k]];
      h[k] = hd_mem[lv * LVL_SZ + st[k]];
    end
    case (t)
      KER_23:  v = (d == 0) ? msum(x[0], x[1]) : x[1] + fl(h[0], x[0]);
      KER_753: begin
        if (d == 0) v = msum(x[0], msum(x[1], x[2]));
        else if (d == 1) v = msum(x[1], x[2]) + fl(h[0], x[0]);
        else v = fl(h[0], x[1]) + fl(h[0] ^ h[1], x[2]);
      end
      KER_427: begin
        if (d == 0) v = msum(x[0], x[2]);
        else if (d == 1) v = msum(x[1], x[2] + fl(h[0], x[0]));
        else v = fl(h[0], x[0]) + fl(h[1], x[1]) + x[2];
      end
      default: begin
        if (d == 0) v = msum(x[0], x[2]);
        else if (d == 1) v = msum(x[1], fl(h[0], x[2]) + x[0]);
        else v = fl(h[0] ^ h[1], x[0]) + fl(h[0], x[1]) + fl(h[1], x[2]);
      end
    endcase
    llr_mem[lv * LVL_SZ + st[d]] = sat16(v);
  endfunction

  function automatic void push_sums(int lv);
    int r, t, d;
    int st[3];
    bit h[3], c[3];
    if (lv >= act_n) return;
    r = radix_at(lv);
    t = kind_at(lv);
    d = dg[lv];
    if (d != r - 1) return;
    h = '{0, 0, 0};
    c = '{0, 0, 0};
    for (int k = 0; k < r; k++) begin
      dg[lv] = k;
      st[k] = site_now();
      h[k] = hd_mem[lv * LVL_SZ + st[k]];
    end
    dg[lv] = d;
    case (t)
      KER_23:  begin c[0] = h[0] ^ h[1]; c[1] = h[1]; end
      KER_753: begin c[0] = h[0] ^ h[1]; c[1] = h[0] ^ h[2]; c[2] = h[0] ^ h[1] ^ h[2]; end
      KER_427: begin c[0] = h[0] ^ h[2]; c[1] = h[1] ^ h[2]; c[2] = h[2]; end
      default: begin c[0] = h[0] ^ h[1] ^ h[2]; c[1] = h[0] ^ h[2]; c[2] = h[1] ^ h[2]; end
    endcase
    for (int k = 0; k < r; k++) hd_mem[(lv + 1) * LVL_SZ + st[k]] = c[k];
    for (int k = 0; k < r; k++) begin
      dg[lv] = k;
      push_sums(lv + 1);
    end
    dg[lv] = d;
  endfunction

  function automatic void decode_cmd(logic [1:0] cmd, int pos, logic signed [15:0] llr, bit dec);
    int p;
    bit_llr_t e;
    geometry();
    if (pos >= act_len) return;
    p = pos;
    for (int s = 0; s < act_n; s++) begin
      dg[s] = p % radix_at(s);
      p /= radix_at(s);
    end
    case (cmd)
      CMD_LOAD: llr_mem[act_n * LVL_SZ + pos] = llr;
      CMD_CALC: begin
        node_llr(0);
        e.pos = pos;
        e.llr = sat16(llr_mem[pos]);
        bit_llr_q.push_back(e);
      end
      CMD_SET: begin
        hd_mem[pos] = dec;
        push_sums(0);
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, bit_llr_t e);
    $display("mismatch %s: got pos %0d llr %0d, expected pos %0d llr %0d @%0t", what,
             m_tdata[12:0], $signed(m_tdata[28:13]), e.pos, e.llr, $realtime);
    errors++;
  endtask

  // checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (bit_llr_q.size() == 0) begin
        $display("unexpected transaction: pos %0d @%0t", m_tdata[12:0], $realtime);
        errors++;
      end else begin
        bit_llr_t e;
        e = bit_llr_q.pop_front();
        if (m_tdata[12:0] != e.pos) report("bit_position", e);
        if ($signed(m_tdata[28:13]) != e.llr) report("bit_llr", e);
      end
    end
  end

  always @(posedge clk) begin
    if (snk_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("[mixed_kernel_polar_sc_decoder_core] ERROR");
      $finish;
    end
  end

  task automatic send(logic [1:0] cmd, int pos, logic signed [15:0] llr, bit dec);
    s_tvalid <= 1'b1;
    s_tdata  <= {dec, llr, pos[12:0], cmd};
    do @(posedge clk); while (!s_tready);
    decode_cmd(cmd, pos, llr, dec);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bit_llr_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_regs(int ns, int kt);
    settle();
    cfg_we <= 1'b1; cfg_index <= CFG_NUM_STAGES; cfg_data <= ns;
    @(posedge clk);
    cfg_index <= CFG_KERNEL_TYPES; cfg_data <= kt;
    @(posedge clk);
    cfg_we <= 1'b0;
    ns_reg = ns;
    kt_reg = kt;
    geometry();
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_llr();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return $urandom;
      default: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
    endcase
  endfunction

  // load every leaf, then decode positions 0..ndec-1 in order; noise_pct adds stray items
  task automatic frame(int ndec, int noise_pct, bit count);
    for (int i = 0; i < act_len; i++) begin
      send(CMD_LOAD, i, pick_llr(), 1'b0);
      if (count) rand_items++;
    end
    for (int i = 0; i < ndec && i < act_len; i++) begin
      send(CMD_CALC, i, $urandom, $urandom);
      send(CMD_SET, i, $urandom, $urandom);
      if (count) rand_items += 2;
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: send(CMD_NONE, $urandom_range(8191), $urandom, $urandom);
          1: send(CMD_CALC, $urandom_range(act_len, 8191), $urandom, $urandom);
          default: send(CMD_CALC, $urandom_range(act_len - 1), $urandom, $urandom);
        endcase
      end
    end
  endtask

  task automatic test_kernels();
    foreach (kt_reg[i]) ;
    for (int k = 0; k < 4; k++) begin
      set_regs(1, k);
      frame(act_len, 0, 1'b0);
    end
    set_regs(0, 16'h0003);
    send(CMD_NONE, 0, 0, 1'b0);
    send(CMD_CALC, 5, 0, 1'b0);
    send(CMD_CALC, 8191, 0, 1'b0);
    frame(act_len, 0, 1'b0);
  endtask

  task automatic test_widest();
    set_regs(15, 16'h0000);
    frame(12, 0, 1'b0);
    set_regs(2, 16'hFFFF);
    frame(act_len, 0, 1'b0);
  endtask

  task automatic test_backpressure();
    set_regs(2, 16'h0001);
    frame(act_len, 0, 1'b0);
    fork
      begin
        snk_hold = 1'b1;
        repeat (3000) @(posedge clk);
        snk_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) send(CMD_CALC, i % act_len, 0, 1'b0);
    join
  endtask

  task automatic test_random();
    int idle_pct[4] = '{0, 64, 0, 27};
    int stall_pct[4] = '{0, 0, 64, 27};
    int ph = 0;
    while (rand_items < 1700) begin
      src_idle_pct = idle_pct[ph % 4];
      snk_stall_pct = stall_pct[ph % 4];
      ph++;
      set_regs($urandom_range(1, 4), $urandom);
      frame(act_len, 10, 1'b1);
      frame($urandom_range(1, act_len), 10, 1'b1);
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    geometry();
    test_kernels();
    test_widest();
    test_backpressure();
    test_random();
    settle();
    if (errors == 0) $display("[mixed_kernel_polar_sc_decoder_core] OK");
    else $display("[mixed_kernel_polar_sc_decoder_core] ERROR");
    $finish;
  end

endmodule
